// File: design/cic4_pkg.sv
// Shared types and constants for the four-stage CIC interpolator.
// No dependencies; every other file in the design imports this package.
`default_nettype none
package cic4_pkg;

    localparam int STAGES      = 4;
    localparam int COMB_GROWTH = 4;
    localparam int OUT_W       = 24;
    localparam int RATE_W      = 3;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 1;

    localparam logic [RATE_W-1:0]    RATE_RESET    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RATE_LOG2 = 1'b0;

    // One integrator update travelling down the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } t_tok;

    // Status of the feed stage that replays one comb result R times.
    typedef struct packed {
        logic busy;
        logic last;
    } t_feed_stat;

endpackage
`default_nettype wire

// File: design/cic4_comb.sv
// Comb cascade: four differences, each against its own one-sample delay.
// Depends on cic4_pkg.
`default_nettype none
module cic4_comb #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_load,
    input  wire logic signed [SAMPLE_WIDTH-1:0]               i_sample,
    output logic signed [SAMPLE_WIDTH+cic4_pkg::COMB_GROWTH-1:0] o_diff
);
    import cic4_pkg::*;

    localparam int COMB_W = SAMPLE_WIDTH + COMB_GROWTH;

    logic signed [COMB_W-1:0] r_dly [STAGES];
    logic signed [COMB_W-1:0] c     [STAGES+1];

    always_comb begin
        c[0] = COMB_W'(i_sample);
        for (int k = 0; k < STAGES; k++) begin
            c[k+1] = c[k] - r_dly[k];
        end
    end

    assign o_diff = c[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_dly[k] <= '0;
            end
        end else if (i_load) begin
            for (int k = 0; k < STAGES; k++) begin
                r_dly[k] <= c[k];
            end
        end
    end

endmodule
`default_nettype wire

// File: design/cic4_integ.sv
// Feed stage and skewed integrator pipeline: the held comb result is issued R
// times and each integrator stage adds the update that the stage before it registered.
// Depends on cic4_pkg.
`default_nettype none
module cic4_integ #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int MAX_RATE_LOG2 = 6
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic                                            i_advance,
    input  wire logic                                            i_in_valid,
    input  wire logic signed [SAMPLE_WIDTH+cic4_pkg::COMB_GROWTH-1:0] i_diff,
    input  wire logic [MAX_RATE_LOG2-1:0]                        i_run_last,
    output logic                                                 o_ready,
    output cic4_pkg::t_feed_stat                                 o_stat,
    output cic4_pkg::t_tok                                       o_tok,
    output logic signed [SAMPLE_WIDTH+4*MAX_RATE_LOG2-1:0]       o_integ
);
    import cic4_pkg::*;

    localparam int INT_W = SAMPLE_WIDTH + 4 * MAX_RATE_LOG2;
    localparam int CNT_W = MAX_RATE_LOG2;

    logic                    r_busy;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [INT_W-1:0] r_feed;
    logic signed [INT_W-1:0] r_int [STAGES];
    t_tok                    r_tok [STAGES];
    logic                    feed_last;
    logic                    accept;

    assign feed_last = (r_cnt == '0);
    assign o_ready   = !r_busy || (i_advance && feed_last);
    assign accept    = i_in_valid && o_ready;
    assign o_stat    = '{busy: r_busy, last: feed_last};
    assign o_tok     = r_tok[STAGES-1];
    assign o_integ   = r_int[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_cnt  <= i_run_last;
        end else if (i_advance && r_busy) begin
            if (feed_last) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_feed <= INT_W'(i_diff);
        end
    end

    // Stage k works on the update that stage k-1 finished at the previous advance,
    // so every integrator sees the same sequence of values as a direct chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_int[k] <= '0;
                r_tok[k] <= '0;
            end
        end else if (i_advance) begin
            if (r_busy) begin
                r_int[0] <= r_int[0] + r_feed;
            end
            r_tok[0] <= '{valid: r_busy, last: feed_last};
            for (int k = 1; k < STAGES; k++) begin
                if (r_tok[k-1].valid) begin
                    r_int[k] <= r_int[k] + r_int[k-1];
                end
                r_tok[k] <= r_tok[k-1];
            end
        end
    end

endmodule
`default_nettype wire

// File: design/cic4_outsat.sv
// Output stage: arithmetic right shift, saturation to 24 bits and the result
// register that parts the pipeline from the downstream stall. Depends on cic4_pkg.
`default_nettype none
module cic4_outsat #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int MAX_RATE_LOG2 = 6
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire cic4_pkg::t_tok                            i_tok,
    input  wire logic signed [SAMPLE_WIDTH+4*MAX_RATE_LOG2-1:0] i_integ,
    input  wire logic [$clog2(4*MAX_RATE_LOG2+1)-1:0]      i_shift,
    input  wire logic                                      i_out_stall,
    output logic                                           o_advance,
    output logic                                           o_out_valid,
    output logic signed [cic4_pkg::OUT_W-1:0]              o_sample_out,
    output logic                                           o_last_of_run
);
    import cic4_pkg::*;

    localparam int INT_W = SAMPLE_WIDTH + 4 * MAX_RATE_LOG2;
    localparam int EXT_W = (INT_W > OUT_W) ? INT_W : OUT_W;

    logic signed [INT_W-1:0] shifted;
    logic signed [EXT_W-1:0] ext;
    logic [EXT_W-OUT_W:0]    upper;
    logic signed [OUT_W-1:0] sat;

    logic                    r_valid;
    logic signed [OUT_W-1:0] r_sample;
    logic                    r_last;

    always_comb begin
        shifted = i_integ >>> i_shift;
        ext     = EXT_W'(shifted);
        upper   = ext[EXT_W-1:OUT_W-1];
        // In range when every bit from the output sign bit upward agrees.
        if ((&upper) || !(|upper)) begin
            sat = ext[OUT_W-1:0];
        end else if (ext[EXT_W-1]) begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    assign o_advance = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_sample <= sat;
            r_last   <= i_tok.last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_sample_out  = r_sample;
    assign o_last_of_run = r_last;

endmodule
`default_nettype wire

// File: design/cic_interpolator_order4.sv
// Four-stage CIC interpolator top level: configuration register, comb cascade,
// integrator pipeline and output stage. Depends on cic4_pkg and the cic4_* modules.
//
// Each input beat yields R = 2^rate_log2 output beats (R = 4 after reset), one
// per clock while the output is not stalled, so the block takes one input per R
// output beats; the single result per cycle from the integrator pipeline sets
// that limit. A new input is taken in the same cycle as the last feed of the
// previous one, so runs follow each other with no gap. The first output of a
// run goes from the feed register, which loads at the edge that accepts its
// input beat, through the four integrator stages to the output register.
// rate_log2 of 0 acts as 1 and values above MAX_RATE_LOG2 act as MAX_RATE_LOG2;
// write it only while the block is idle.
`default_nettype none
module cic_interpolator_order4 #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int MAX_RATE_LOG2 = 6
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       i_sample_in,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [cic4_pkg::OUT_W-1:0]         o_sample_out,
    output logic                                      o_last_of_run,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [cic4_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [cic4_pkg::PDATA_W-1:0]         pwdata,
    output logic [cic4_pkg::PDATA_W-1:0]              prdata,
    output logic                                      pready
);
    import cic4_pkg::*;

    localparam int COMB_W = SAMPLE_WIDTH + COMB_GROWTH;
    localparam int INT_W  = SAMPLE_WIDTH + 4 * MAX_RATE_LOG2;
    localparam int CNT_W  = MAX_RATE_LOG2;
    localparam int SH_W   = $clog2(4 * MAX_RATE_LOG2 + 1);

    logic [RATE_W-1:0]       r_rate;
    logic [RATE_W-1:0]       eff_rate;
    logic [CNT_W-1:0]        run_last;
    logic [SH_W-1:0]         shift;
    logic                    cfg_wr;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    in_ready;
    logic                    in_accept;
    logic                    advance;
    logic signed [COMB_W-1:0] comb_diff;
    t_feed_stat              feed_stat;
    t_tok                    tail_tok;
    logic signed [INT_W-1:0] tail_integ;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (cfg_wr && (reg_idx == REG_RATE_LOG2)) begin
            r_rate <= pwdata[RATE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_RATE_LOG2) begin
            prdata[RATE_W-1:0] = r_rate;
        end
    end

    always_comb begin
        priority if (r_rate == '0) begin
            eff_rate = RATE_W'(1);
        end else if (r_rate > RATE_W'(MAX_RATE_LOG2)) begin
            eff_rate = RATE_W'(MAX_RATE_LOG2);
        end else begin
            eff_rate = r_rate;
        end
    end

    assign run_last = CNT_W'((1 << eff_rate) - 1);
    assign shift    = SH_W'({eff_rate, 2'b00});

    assign o_in_stall = !in_ready;
    assign in_accept  = i_in_valid && in_ready;

    cic4_comb #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_comb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_sample (i_sample_in),
        .o_diff   (comb_diff)
    );

    cic4_integ #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .MAX_RATE_LOG2 (MAX_RATE_LOG2)
    ) u_integ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_in_valid (i_in_valid),
        .i_diff     (comb_diff),
        .i_run_last (run_last),
        .o_ready    (in_ready),
        .o_stat     (feed_stat),
        .o_tok      (tail_tok),
        .o_integ    (tail_integ)
    );

    cic4_outsat #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .MAX_RATE_LOG2 (MAX_RATE_LOG2)
    ) u_outsat (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok         (tail_tok),
        .i_integ       (tail_integ),
        .i_shift       (shift),
        .i_out_stall   (i_out_stall),
        .o_advance     (advance),
        .o_out_valid   (o_out_valid),
        .o_sample_out  (o_sample_out),
        .o_last_of_run (o_last_of_run)
    );

    // Reset leaves the pipeline empty and ready for a beat.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // An accepted beat always starts a run in the feed stage.
    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> feed_stat.busy)
        else $error("accepted beat did not start a run");

    // Inputs are held off while a run still has feeds other than its last.
    a_stall_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (feed_stat.busy && !feed_stat.last) |-> o_in_stall)
        else $error("input taken in the middle of a run");

endmodule
`default_nettype wire
